>>> design/nmacl_pkg.sv
// ---------------------------------------------------------------------------
// nmacl_pkg: shared types and codes of the network mask access list
// operation codes, result status codes and the entry, comparator key and result records
// ---------------------------------------------------------------------------
package nmacl_pkg;

    localparam int AddrW       = 32;
    localparam int OpW         = 2;
    localparam int StatusW     = 2;
    localparam int EntryCountW = 5;

    localparam logic [OpW-1:0] OP_ADD   = 2'd0;
    localparam logic [OpW-1:0] OP_CHECK = 2'd1;
    localparam logic [OpW-1:0] OP_CLEAR = 2'd2;

    localparam logic [StatusW-1:0] ST_ADDED     = 2'd0;
    localparam logic [StatusW-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [StatusW-1:0] ST_FULL      = 2'd2;
    localparam logic [StatusW-1:0] ST_DONE      = 2'd3;

    // one table row
    typedef struct packed {
        logic [AddrW-1:0] net;
        logic [AddrW-1:0] mask;
    } t_entry;

    // operands held for the shared comparator
    typedef struct packed {
        logic             add;
        logic [AddrW-1:0] net;
        logic [AddrW-1:0] mask;
        logic [AddrW-1:0] addr;
    } t_cmp_key;

    // one result item
    typedef struct packed {
        logic [StatusW-1:0]     status;
        logic                   allowed;
        logic [EntryCountW-1:0] entry_count;
    } t_result;

endpackage

>>> design/nmacl_store.sv
// ---------------------------------------------------------------------------
// nmacl_store: entry table memory
// one write port and one read port with registered read data
// ---------------------------------------------------------------------------
module nmacl_store #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  nmacl_pkg::t_entry    i_wr_entry,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output nmacl_pkg::t_entry    o_rd_entry
);
    import nmacl_pkg::*;

    t_entry r_mem [0:DEPTH-1];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

>>> design/nmacl_cmp.sv
// ---------------------------------------------------------------------------
// nmacl_cmp: shared entry comparator
// one 64-bit equality used for the duplicate test and the address match
// ---------------------------------------------------------------------------
module nmacl_cmp (
    input  nmacl_pkg::t_cmp_key i_key,
    input  nmacl_pkg::t_entry   i_entry,
    output logic                o_match
);
    import nmacl_pkg::*;

    logic [2*AddrW-1:0] lhs;
    logic [2*AddrW-1:0] rhs;

    always_comb begin
        if (i_key.add) begin
            // exact pair
            lhs = {i_entry.net, i_entry.mask};
            rhs = {i_key.net, i_key.mask};
        end else begin
            // client address under the entry mask
            lhs = {i_entry.net & i_entry.mask, {AddrW{1'b0}}};
            rhs = {i_key.addr & i_entry.mask, {AddrW{1'b0}}};
        end
    end

    assign o_match = (lhs == rhs);

endmodule

>>> design/nmacl_ctrl.sv
// ---------------------------------------------------------------------------
// nmacl_ctrl: sequencer of the access list
// walks the stored entries through the comparator, keeps the fill count
// and holds the result item until it is taken
// ---------------------------------------------------------------------------
module nmacl_ctrl #(
    parameter int MAX_ENTRIES = 16,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [nmacl_pkg::OpW-1:0]   i_op,
    input  logic [nmacl_pkg::AddrW-1:0] i_addr,
    input  logic [nmacl_pkg::AddrW-1:0] i_mask,
    input  logic                        i_cred,
    output logic                        o_rd_en,
    output logic [IDX_W-1:0]            o_rd_addr,
    output logic                        o_wr_en,
    output logic [IDX_W-1:0]            o_wr_addr,
    output nmacl_pkg::t_entry           o_wr_entry,
    output nmacl_pkg::t_cmp_key         o_key,
    input  logic                        i_match,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output nmacl_pkg::t_result          o_res
);
    import nmacl_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_ENTRIES);

    logic [1:0]       r_state, n_state;
    logic [OpW-1:0]   r_op, n_op;
    logic [AddrW-1:0] r_addr, n_addr;
    logic [AddrW-1:0] r_mask, n_mask;
    logic [AddrW-1:0] r_net, n_net;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic             r_rd_vld, n_rd_vld;
    logic             r_hit, n_hit;
    logic             r_o_valid, n_o_valid;
    t_result          r_res, n_res;

    logic accept;
    logic issue;
    logic out_free;
    logic full;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign issue    = (r_state == S_WALK) && (r_pos < r_count);
    assign out_free = !r_o_valid || i_res_ready;
    assign full     = (r_count >= CntMax);

    assign o_ready   = (r_state == S_IDLE);
    assign o_rd_en   = issue;
    assign o_rd_addr = r_pos[IDX_W-1:0];
    assign o_wr_addr = r_count[IDX_W-1:0];
    assign o_wr_entry = '{net: r_net, mask: r_mask};
    assign o_wr_en   = (r_state == S_FINISH) && out_free && (r_op == OP_ADD)
                       && !r_hit && !full;
    assign o_key     = '{add: (r_op == OP_ADD), net: r_net, mask: r_mask, addr: r_addr};
    assign o_res_valid = r_o_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_addr    = r_addr;
        n_mask    = r_mask;
        n_net     = r_net;
        n_count   = r_count;
        n_pos     = r_pos;
        n_rd_vld  = 1'b0;
        n_hit     = r_hit;
        n_o_valid = r_o_valid && !i_res_ready;
        n_res     = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op   = i_op;
                    n_addr = i_addr;
                    n_mask = i_mask;
                    n_net  = i_addr & i_mask;
                    n_pos  = '0;
                    n_hit  = 1'b0;
                    if ((i_op == OP_ADD || i_op == OP_CHECK) && r_count != '0) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_WALK: begin
                if (issue) begin
                    n_pos = r_pos + 1'b1;
                end
                n_rd_vld = issue;
                if (r_rd_vld && i_match) begin
                    n_hit    = 1'b1;
                    n_rd_vld = 1'b0;
                    n_state  = S_FINISH;
                end else if (!issue) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_res.allowed = 1'b0;
                    n_res.status  = ST_DONE;
                    unique case (r_op)
                        OP_ADD: begin
                            if (r_hit) begin
                                n_res.status = ST_DUPLICATE;
                            end else if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_res.status = ST_ADDED;
                                n_count      = r_count + 1'b1;
                            end
                        end
                        OP_CHECK: begin
                            n_res.allowed = r_hit || (r_count == '0 && i_cred);
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_res.entry_count = EntryCountW'(n_count);
                    n_o_valid         = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pos     <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pos     <= n_pos;
            r_rd_vld  <= n_rd_vld;
            r_hit     <= n_hit;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_addr <= n_addr;
        r_mask <= n_mask;
        r_net  <= n_net;
        r_res  <= n_res;
    end

    // an accepted item blocks the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("input accepted twice in a row");

    // fill count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_count <= CntMax && r_pos <= r_count))
        else $error("walk position or count out of range");

    // a stored add bumps the count by one and posts a result
    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |=> (r_count == $past(r_count) + 1'b1) && r_o_valid)
        else $error("add did not advance the count");

    // compare data only follows a read in the walk
    a_rd_vld_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ($past(r_state) == S_WALK) && ($past(o_rd_en)))
        else $error("compare without a read");

    // clear empties the table
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && out_free && r_op == OP_CLEAR) |=>
            (r_count == '0 && r_o_valid))
        else $error("clear left entries");

endmodule

>>> design/network_mask_access_list_core.sv
// ---------------------------------------------------------------------------
// network_mask_access_list_core: ipv4 network and mask access list
// stores allowed network/mask pairs, skips duplicates and checks client
// addresses against every entry with one shared comparator
// ---------------------------------------------------------------------------
//  channel  | direction | handshake              | content
//  ---------+-----------+------------------------+-------------------------------
//  s        | in        | i_s_tvalid/o_s_tready  | tuser op, tdata address,netmask
//  m        | out       | o_m_tvalid/i_m_tready  | tuser status, tdata allowed,count
//  cfg      | in        | i_cfg_we               | credentials_enabled
//
//  add and check read and compare the stored entries one after another until
//  a match or the last entry: one table read and one compare per entry
//  through the single memory read port and the shared comparator
//  clear, an unused op and items on an empty table skip the table walk
//  reset (synchronous, active low) empties the table and drops the credentials
//  flag; table contents are not cleared, only rows below the count are read
//  a result waits in the output register; a stall there holds the sequencer
//  in its final step and the next item is not taken until the result is loaded
// ---------------------------------------------------------------------------
module network_mask_access_list_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] address, [63:32] netmask
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] allowed, [5:1] entry_count, [7:6] zero
    output logic [1:0]  o_m_tuser,   // [1:0] status
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata  // credentials_enabled
);
    import nmacl_pkg::*;

    localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CntW = $clog2(MAX_ENTRIES + 1);

    // credentials mode register
    logic r_cred;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= 1'b0;
        end else if (i_cfg_we) begin
            r_cred <= i_cfg_wdata;
        end
    end

    // table access
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    t_entry          wr_entry;
    t_entry          rd_entry;

    // comparator
    t_cmp_key key;
    logic     match;

    // result
    logic    res_valid;
    t_result res;

    nmacl_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IdxW),
        .CNT_W       (CntW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (i_s_tuser),
        .i_addr      (i_s_tdata[31:0]),
        .i_mask      (i_s_tdata[63:32]),
        .i_cred      (r_cred),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_entry  (wr_entry),
        .o_key       (key),
        .i_match     (match),
        .o_res_valid (res_valid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    nmacl_store #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IdxW)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry)
    );

    // registered row against the held operands
    nmacl_cmp u_cmp (
        .i_key   (key),
        .i_entry (rd_entry),
        .o_match (match)
    );

    // output packing
    assign o_m_tvalid = res_valid;
    assign o_m_tuser  = res.status;
    assign o_m_tdata  = {2'b00, res.entry_count, res.allowed};

endmodule

>>> tb/sv/network_mask_access_list_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// network_mask_access_list_checker: scoreboard for the access list core
// watches the item and configuration channels, keeps its own copy of the
// table and the credentials flag, and checks every result item in order
// ---------------------------------------------------------------------------
module network_mask_access_list_checker #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] address, [63:32] netmask
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [0] allowed, [5:1] entry_count
    input  logic [1:0]  i_m_tuser,   // [1:0] status
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    import nmacl_pkg::*;

    logic [AddrW-1:0]       net_tbl  [MAX_ENTRIES];
    logic [AddrW-1:0]       mask_tbl [MAX_ENTRIES];
    int                     n_entries;
    logic                   cred_mode;
    t_result                awaited_verdicts [$];
    int                     fails   = 0;
    int                     waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    task automatic predict_verdict(input logic [OpW-1:0] op, input logic [AddrW-1:0] addr,
                                   input logic [AddrW-1:0] mask);
        t_result          r;
        logic [AddrW-1:0] net;
        logic             hit;
        int               k;
        r.status  = ST_DONE;
        r.allowed = 1'b0;
        net       = addr & mask;
        hit       = 1'b0;
        unique case (op)
            OP_ADD: begin
                for (k = 0; k < n_entries; k++)
                    if (net_tbl[k] == net && mask_tbl[k] == mask)
                        hit = 1'b1;
                if (hit) begin
                    r.status = ST_DUPLICATE;
                end else if (n_entries >= MAX_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    net_tbl[n_entries]  = net;
                    mask_tbl[n_entries] = mask;
                    n_entries           = n_entries + 1;
                    r.status            = ST_ADDED;
                end
            end
            OP_CHECK: begin
                for (k = 0; k < n_entries; k++)
                    if ((net_tbl[k] & mask_tbl[k]) == (addr & mask_tbl[k]))
                        hit = 1'b1;
                r.allowed = hit || (n_entries == 0 && cred_mode);
            end
            OP_CLEAR: begin
                n_entries = 0;
            end
            default: ;
        endcase
        r.entry_count = EntryCountW'(n_entries);
        awaited_verdicts.push_back(r);
    endtask

    task automatic compare_verdict();
        t_result want;
        if (awaited_verdicts.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual status %0d tdata 0x%02h",
                     $time, i_m_tuser, i_m_tdata);
            fails++;
        end else begin
            want = awaited_verdicts.pop_front();
            if (i_m_tuser != want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, i_m_tuser);
                fails++;
            end
            if (i_m_tdata[0] != want.allowed) begin
                $display("%0t: allowed mismatch, expected %0d, actual %0d",
                         $time, want.allowed, i_m_tdata[0]);
                fails++;
            end
            if (i_m_tdata[5:1] != want.entry_count) begin
                $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                         $time, want.entry_count, i_m_tdata[5:1]);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_entries = 0;
            cred_mode = 1'b0;
            awaited_verdicts.delete();
            waiting <= 0;
        end else begin
            if (i_cfg_we)
                cred_mode = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready)
                predict_verdict(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32]);
            if (i_m_tvalid && i_m_tready)
                compare_verdict();
            waiting <= awaited_verdicts.size();
        end
    end

endmodule

>>> tb/sv/network_mask_access_list_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// network_mask_access_list_core_test: testbench top for the access list core
// directed items on the table edges, then random add, check, clear and unused-op items
// under several idling patterns and credentials settings; a separate checker
// predicts and compares every result item
// ---------------------------------------------------------------------------
module network_mask_access_list_core_test;

    import nmacl_pkg::*;

    localparam int              MAX_ENTRIES    = 16;
    localparam int              ITEMS_PER_RUN  = 112;  // items in each of the four random phases
    localparam int              HOLD_CYCLES    = 300;  // long receiver hold-off
    localparam int              SETTLE_CYCLES  = 25;
    localparam int              WATCHDOG_LIMIT = 3000;
    localparam logic [OpW-1:0]  OP_UNUSED      = 2'd3;

    // clock, reset and block inputs, all known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;

    // block outputs
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;

    // checker status
    int          fail_count;
    int          pending;

    // idling knobs, percent of cycles
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          hold_req       = 1'b0;
    int          idle_cycles    = 0;

    // recently added pairs, used to aim duplicates and matching checks
    logic [31:0] pool_addr [32];
    logic [31:0] pool_mask [32];
    int          pool_n = 0;

    network_mask_access_list_core #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    network_mask_access_list_checker #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 10 ns clock
    initial begin
        forever #5 clk = ~clk;
    end

    // prefix mask, length 0 gives an empty mask, 32 a single host
    function automatic logic [31:0] prefix_mask(input int len);
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    // offer one item, optionally after a random gap, and wait for acceptance
    // tvalid stays high afterwards so back-to-back items need no re-raise
    task automatic send_item(input logic [OpW-1:0] op, input logic [31:0] addr,
                             input logic [31:0] mask);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mask, addr};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        if (op == OP_ADD) begin
            pool_addr[pool_n % 32] = addr;
            pool_mask[pool_n % 32] = mask;
            pool_n++;
        end
    endtask

    // stop offering and wait until every expected result item has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // credentials flag, only written while the block is idle
    task automatic write_cred(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one random item: adds build up the table (often to full), checks are
    // aimed at stored networks half the time, clears and unused ops are rare
    task automatic random_item();
        int          pick;
        int          k;
        logic [31:0] a;
        logic [31:0] m;
        pick = $urandom_range(99);
        if (pool_n > 0)
            k = $urandom_range(((pool_n < 32) ? pool_n : 32) - 1);
        else
            k = 0;
        if (pick < 50) begin
            if (pool_n > 0 && $urandom_range(3) == 0) begin
                // same pair again, host bits outside the mask scrambled
                m = pool_mask[k];
                a = (pool_addr[k] & m) | ($urandom & ~m);
            end else begin
                if ($urandom_range(9) == 0)
                    m = $urandom;
                else if ($urandom_range(3) == 0)
                    m = prefix_mask($urandom_range(32));
                else
                    m = prefix_mask($urandom_range(32, 16));
                a = $urandom;
            end
            send_item(OP_ADD, a, m);
        end else if (pick < 92) begin
            if (pool_n > 0 && $urandom_range(1) == 1)
                a = (pool_addr[k] & pool_mask[k]) | ($urandom & ~pool_mask[k]);
            else
                a = $urandom;
            send_item(OP_CHECK, a, $urandom);
        end else if (pick < 95) begin
            send_item(OP_CLEAR, $urandom, $urandom);
        end else begin
            send_item(OP_UNUSED, $urandom, $urandom);
        end
    endtask

    // receiver: random stalls, or one long hold-off when asked for
    initial begin
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("network_mask_access_list_core_test NOT OK");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        int ph;
        int i;
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table without credentials refuses the client
        write_cred(1'b0);
        send_item(OP_CHECK, 32'h0102_0304, 32'h0);
        drain();

        // directed part with credentials on
        write_cred(1'b1);
        send_item(OP_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF);  // empty table lets anyone in
        send_item(OP_UNUSED, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_item(OP_CLEAR,  32'h0,         32'h0);          // clear on empty
        send_item(OP_ADD,    32'hC0A8_0164, 32'hFFFF_FF00);  // host bits outside the mask
        send_item(OP_ADD,    32'hC0A8_0100, 32'hFFFF_FF00);  // same masked network
        send_item(OP_ADD,    32'hC0A8_0164, 32'hFFFF_FFFF);  // single host
        send_item(OP_CHECK,  32'h0A00_0001, 32'h0);          // no match, credentials ignored
        send_item(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_ADD,    32'h1234_5678, 32'h0000_0000);  // empty mask matches everyone
        for (k = 0; k < MAX_ENTRIES - 4; k++)
            send_item(OP_ADD, 32'h0A00_0000 + k, 32'hFFFF_FFFF);
        send_item(OP_ADD,    32'h0B00_0000, 32'hFFFF_FFFF);  // table full
        send_item(OP_ADD,    32'hC0A8_01AA, 32'hFFFF_FF00);  // duplicate wins over full
        send_item(OP_UNUSED, 32'h0,         32'h0);          // count held at sixteen
        send_item(OP_CHECK,  32'h0A00_00FF, 32'h0);
        send_item(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_CHECK,  32'h0A00_0001, 32'h0);          // empty again, credentials on
        drain();

        // random phases: no idling, idle sender, stalling receiver, both
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            write_cred(ph[0]);
            for (i = 0; i < ITEMS_PER_RUN; i++) begin
                // long output hold-off while items keep coming
                if (ph == 0 && i == 30)
                    hold_req = 1'b1;
                // sender waits for the block to empty mid-phase
                if (ph == 1 && i == ITEMS_PER_RUN / 2)
                    drain();
                random_item();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("network_mask_access_list_core_test OK");
        else
            $display("network_mask_access_list_core_test NOT OK");
        $finish;
    end

endmodule
